// ===== rtl/ptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
package ptw_pkg;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ENT_W   = 64;
  localparam int FRAME_W = 40;
  localparam int WORD_W  = FRAME_W + IDX_W;
  localparam int ROOT_W  = 15;
  localparam int WIDX_W  = 12;

  localparam int PRESENT_BIT = 0;
  localparam int HUGE_BIT    = 7;

  localparam logic [PA_W-1:0] OFS_1G = 52'h3FFFFFFF;
  localparam logic [PA_W-1:0] OFS_2M = 52'h1FFFFF;
  localparam logic [PA_W-1:0] OFS_4K = 52'hFFF;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_4K   = 2'd1;
  localparam logic [1:0] PS_2M   = 2'd2;
  localparam logic [1:0] PS_1G   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic            in_range;
    logic            present;
    logic            leaf;
    logic [1:0]      size;
    logic [PA_W-1:0] pa;
  } step_t;

endpackage

// ===== rtl/ptw_ram.sv =====
// Generic single-port RAM with registered read data.
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ptw_step.sv =====
// Shared walk unit: table word address, range check, entry decode and address sum.
module ptw_step #(
  parameter int STORE_WORDS = 4096
) (
  input  logic [ptw_pkg::FRAME_W-1:0]   look_tbl,
  input  logic [1:0]                    look_level,
  input  logic [1:0]                    dec_level,
  input  logic [ptw_pkg::VA_W-1:0]      va,
  input  logic [ptw_pkg::ENT_W-1:0]     ent,
  output logic [$clog2(STORE_WORDS)-1:0] addr,
  output ptw_pkg::step_t                st
);
  import ptw_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] word;
  logic [PA_W-1:0]   ofs_mask;
  logic              huge;
  logic              in_range;
  logic              present;
  logic              is_leaf;
  logic [1:0]        leaf_sz;
  logic [PA_W-1:0]   pa;

  always_comb begin
    case (look_level)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      LVL_PT:   idx = va[20:12];
      default:  idx = va[20:12];
    endcase
  end

  assign word     = {look_tbl, idx};
  assign addr     = word[AW-1:0];
  assign in_range = word < WORD_W'(STORE_WORDS);

  assign huge    = ent[HUGE_BIT];
  assign present = ent[PRESENT_BIT];

  always_comb begin
    is_leaf  = 1'b0;
    leaf_sz  = PS_NONE;
    ofs_mask = OFS_4K;
    case (dec_level)
      LVL_PDPT: begin
        if (huge) begin
          is_leaf  = 1'b1;
          leaf_sz  = PS_1G;
          ofs_mask = OFS_1G;
        end
      end
      LVL_PD: begin
        if (huge) begin
          is_leaf  = 1'b1;
          leaf_sz  = PS_2M;
          ofs_mask = OFS_2M;
        end
      end
      LVL_PT: begin
        is_leaf = 1'b1;
        leaf_sz = PS_4K;
      end
      default: begin
        is_leaf = 1'b0;
      end
    endcase
  end

  assign pa = {ent[51:12], 12'b0} + (PA_W'(va) & ofs_mask);

  assign st = {in_range, present, is_leaf, leaf_sz, pa};

endmodule

// ===== rtl/page_table_walk_translate_top.sv =====
// Top level of the four-level page table walker with its local table store.
//
// The block holds a store of STORE_WORDS 64-bit table words. Each input word
// either writes one table word (req_type 0) or translates virt_addr (req_type 1)
// by walking the PML4, PDPT, PD and PT levels from the root register.
// The root register is written over the cfg channel, which is always ready.
// Every input word gives exactly one output word; a write gives all zeros.
// A write goes straight to the result state, which loads the output register.
// A translation issues the first table read in the lookup state, then visits
// one to four levels in the check state, each a dependent read of the
// registered store, and loads the output register in the result state; it
// skips the check state when the root table lies outside the store.
// in_ready is high only while no word is being processed and returns together
// with out_valid once the output register loads. The result sits in an output
// register, so a stalled receiver holds one result while the block finishes
// the next word and waits to hand it over.
// Reset clears the root register and the control state. The table store is
// not cleared, and a word must be written before a walk reads it.
module page_table_walk_translate_top #(
  parameter int STORE_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] root_table_addr,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [11:0] word_index,
  input  logic [63:0] word_data,
  input  logic [47:0] virt_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [51:0] phys_addr,
  output logic        mapped,
  output logic [1:0]  leaf_size,
  output logic        walk_fault
);
  import ptw_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  state_t             state, state_next;
  logic [ROOT_W-1:0]  root;
  logic [1:0]         level;
  logic [FRAME_W-1:0] tbl;
  logic [VA_W-1:0]    va;
  logic [PA_W-1:0]    res_pa;
  logic [1:0]         res_size;
  logic               res_fault;

  logic [ENT_W-1:0]   ent;
  logic [FRAME_W-1:0] look_tbl;
  logic [1:0]         look_level;
  logic [AW-1:0]      look_addr;
  step_t              st;

  logic [31:0]        wr_word;
  logic               wr_in_range;
  logic               accept;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic               load_out;

  assign cfg_ready   = 1'b1;
  assign accept      = in_valid && in_ready;
  assign wr_word     = 32'(word_index);
  assign wr_in_range = wr_word < 32'(STORE_WORDS);

  assign look_tbl   = (state == S_CHECK) ? ent[51:12] : tbl;
  assign look_level = (state == S_CHECK) ? 2'(level + 2'd1) : level;

  ptw_step #(
    .STORE_WORDS(STORE_WORDS)
  ) u_step (
    .look_tbl  (look_tbl),
    .look_level(look_level),
    .dec_level (level),
    .va        (va),
    .ent       (ent),
    .addr      (look_addr),
    .st        (st)
  );

  ptw_ram #(
    .WIDTH(ENT_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(word_data),
    .rdata(ent)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (req_type == REQ_XLATE) ? S_LOOKUP : S_RESULT;
        end
      end
      S_LOOKUP: begin
        state_next = st.in_range ? S_CHECK : S_RESULT;
      end
      S_CHECK: begin
        if (!st.present || st.leaf || !st.in_range) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_addr = look_addr;
    load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ram_addr = wr_word[AW-1:0];
        ram_we   = in_valid && (req_type == REQ_WRITE) && wr_in_range;
      end
      S_RESULT: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      root      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        root <= root_table_addr;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          va        <= virt_addr;
          tbl       <= FRAME_W'(root[14:12]);
          level     <= LVL_PML4;
          res_pa    <= '0;
          res_size  <= PS_NONE;
          res_fault <= 1'b0;
        end
      end
      S_LOOKUP: begin
        if (!st.in_range) begin
          res_fault <= 1'b1;
        end
      end
      S_CHECK: begin
        if (st.present) begin
          if (st.leaf) begin
            res_pa   <= st.pa;
            res_size <= st.size;
          end else if (!st.in_range) begin
            res_fault <= 1'b1;
          end else begin
            tbl   <= ent[51:12];
            level <= look_level;
          end
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      phys_addr  <= res_pa;
      mapped     <= res_pa != '0;
      leaf_size  <= res_size;
      walk_fault <= res_fault;
    end
  end

`ifndef SYNTHESIS
  a_mapped_matches_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mapped == (phys_addr != '0)))
    else $error("mapped does not match the translated address");

  a_fault_clears_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && walk_fault |-> (phys_addr == '0) && (leaf_size == PS_NONE))
    else $error("faulted walk returned a translation");

  a_check_follows_lookup: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> ($past(state) == S_LOOKUP) || ($past(state) == S_CHECK))
    else $error("entry check entered without a table read");
`endif

endmodule
